/* rtl/core/csv_record_tokenizer_assert.svh */
// Assertion macros for the CSV record tokenizer.
`ifndef CSV_RECORD_TOKENIZER_ASSERT_SVH
`define CSV_RECORD_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define CSVTOK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSVTOK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSVTOK_ASSERT(lbl, clk, rst, prop, msg)
`define CSVTOK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/csvtok_pkg.sv */
`timescale 1ns / 1ps

package csvtok_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } csvtok_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } csvtok_out_t;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic cr_pending;
    logic field_has_data;
    logic record_has_fields;
  } csvtok_state_t;

endpackage

/* rtl/core/csvtok_step.sv */
`timescale 1ns / 1ps

module csvtok_step (
  input  csvtok_pkg::csvtok_state_t state,
  input  csvtok_pkg::csvtok_in_t    word,
  output csvtok_pkg::csvtok_state_t state_next,
  output logic                      emit,
  output csvtok_pkg::csvtok_out_t   result
);
  import csvtok_pkg::*;

  always_comb begin
    logic       skip;
    logic       done;
    logic [7:0] c;
    c          = word.char_byte;
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    skip       = 1'b0;
    done       = 1'b0;
    if (word.end_of_input) begin
      state_next = '0;
      if (state.in_quotes && !state.quote_pending) begin
        emit        = 1'b1;
        result.kind = KIND_ERROR;
      end else if (state.field_has_data || state.record_has_fields) begin
        emit        = 1'b1;
        result.kind = KIND_RECORD;
      end
    end else begin
      if (state.cr_pending) begin
        state_next.cr_pending = 1'b0;
        skip = (c == CH_LF);
      end
      if (!skip) begin
        if (state.quote_pending) begin
          state_next.quote_pending = 1'b0;
          if (c == CH_QUOTE) begin
            state_next.field_has_data = 1'b1;
            emit             = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = c;
            done             = 1'b1;
          end else begin
            state_next.in_quotes = 1'b0;
          end
        end
        if (!done) begin
          if (c == CH_QUOTE) begin
            if (state_next.in_quotes) begin
              state_next.quote_pending = 1'b1;
            end else begin
              state_next.in_quotes = 1'b1;
            end
          end else if (!state_next.in_quotes && c == CH_COMMA) begin
            state_next.field_has_data    = 1'b0;
            state_next.record_has_fields = 1'b1;
            emit        = 1'b1;
            result.kind = KIND_FIELD;
          end else if (!state_next.in_quotes && (c == CH_LF || c == CH_CR)) begin
            state_next.field_has_data    = 1'b0;
            state_next.record_has_fields = 1'b0;
            state_next.cr_pending        = (c == CH_CR);
            emit        = 1'b1;
            result.kind = KIND_RECORD;
          end else begin
            state_next.field_has_data = 1'b1;
            emit             = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = c;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/csv_record_tokenizer.sv */
`timescale 1ns / 1ps
// CSV record tokenizer.
// text channel (text_valid / text_ready / text_word): one word per byte of
//   CSV text, or a word with end_of_input set to close the stream.
// tok channel (tok_valid / tok_ready / tok_word): zero or one token per text
//   word: a data byte, a field end, a field and record end, or an error for
//   text that ends inside quotes.
// A word lands in the input register at accept, and its token lands in the
//   output register when that word advances, which a held token can delay.
// Throughput: one word per cycle while tok_ready does not hold a token
//   back, set by the combinational quote, CR and field flag update between
//   the input and output registers.
// A word that yields no token still advances and frees the input register.
// Reset clears both registers' valid flags and all parse flags.
// When tok_ready is low the token holds; one more word waits in the input
//   register, then text_ready drops until the token is taken.
// End of input returns every parse flag to its reset value.
module csv_record_tokenizer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_ready,
  input  csvtok_pkg::csvtok_in_t text_word,
  output logic                   tok_valid,
  input  logic                   tok_ready,
  output csvtok_pkg::csvtok_out_t tok_word
);
  import csvtok_pkg::*;
`include "csv_record_tokenizer_assert.svh"

  logic          hold_valid;
  csvtok_in_t    hold_word;
  csvtok_state_t state;
  csvtok_state_t state_next;
  logic          emit;
  csvtok_out_t   result;
  logic          advance;

  assign advance    = hold_valid && (!tok_valid || tok_ready);
  assign text_ready = !hold_valid || advance;

  csvtok_step u_step (
    .state      (state),
    .word       (hold_word),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_ready) begin
      hold_valid <= text_valid;
    end
    if (text_ready && text_valid) begin
      hold_word <= text_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      tok_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance && emit) begin
        tok_valid <= 1'b1;
      end else if (tok_ready) begin
        tok_valid <= 1'b0;
      end
    end
    if (advance && emit) begin
      tok_word <= result;
    end
  end

  `CSVTOK_ASSERT(a_pad_zero, clk, rst,
    tok_valid && tok_word.kind != KIND_DATA |-> tok_word.data_byte == 8'd0,
    "non-data token carries a byte")
  `CSVTOK_ASSERT(a_end_clears, clk, rst,
    advance && hold_word.end_of_input |=> state == '0, "end of input left state")
  `CSVTOK_ASSERT(a_qp_in_quotes, clk, rst,
    state.quote_pending |-> state.in_quotes, "pending quote outside quotes")
  `CSVTOK_ASSERT(a_cr_outside, clk, rst,
    state.cr_pending |-> !state.in_quotes && !state.quote_pending,
    "pending CR inside quotes")
  `CSVTOK_ASSERT_ALWAYS(a_ready_when_empty, clk,
    !rst && !tok_valid |-> text_ready, "stalled with empty output")

endmodule
